>>> hw/rtl/multivariate_poly_eval_mod_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion helpers for the polynomial evaluator.
// ----------------------------------------------------------------------------
`ifndef MULTIVARIATE_POLY_EVAL_MOD_CORE_MACROS_SVH
`define MULTIVARIATE_POLY_EVAL_MOD_CORE_MACROS_SVH

// same-cycle implication
`define MPE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MPE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/mpe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpe_pkg
// Types and constants for the polynomial evaluator.
// ----------------------------------------------------------------------------
package mpe_pkg;

    localparam int WORD_W  = 64;
    localparam int EXP_W   = 16;
    localparam int VARS    = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CNT_W   = 6;

    localparam logic [CFG_IDX_W-1:0] REG_MODULUS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_3 = 3'd4;

    typedef enum logic [0:0] {
        OP_REDUCE = 1'b0,
        OP_MUL    = 1'b1
    } mm_op_t;

    typedef struct packed {
        logic              start;
        mm_op_t            op;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
    } mm_cmd_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [WORD_W-1:0] result;
    } mm_stat_t;

endpackage

>>> hw/rtl/mpe_mulmod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpe_mulmod
// Bit-serial modular unit: a*b mod n, or b mod n, one bit per cycle.
// ----------------------------------------------------------------------------
module mpe_mulmod
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [mpe_pkg::WORD_W-1:0]  n,
    input  mpe_pkg::mm_cmd_t            cmd,
    output mpe_pkg::mm_stat_t           stat
);

    localparam int W = mpe_pkg::WORD_W;

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [mpe_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    mpe_pkg::mm_op_t                op_reg, op_next;
    logic [W-1:0]                   a_reg, a_next;
    logic [W-1:0]                   b_reg, b_next;
    logic [W-1:0]                   r_reg, r_next;
    logic [W:0]                     t1, t2, n_ext;
    logic                           bin;

    always_comb
    begin
        n_ext = {1'b0, n};
        bin   = (op_reg == mpe_pkg::OP_REDUCE) ? b_reg[W-1] : 1'b0;
        t1    = {r_reg, bin};
        if (t1 >= n_ext)
        begin
            t1 = t1 - n_ext;
        end
        t2 = t1;
        if (op_reg == mpe_pkg::OP_MUL && b_reg[W-1])
        begin
            t2 = t1 + {1'b0, a_reg};
            if (t2 >= n_ext)
            begin
                t2 = t2 - n_ext;
            end
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        r_next    = r_reg;
        if (busy_reg)
        begin
            r_next   = t2[W-1:0];
            b_next   = {b_reg[W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (cmd.start)
        begin
            busy_next = 1'b1;
            cnt_next  = mpe_pkg::CNT_W'(W - 1);
            op_next   = cmd.op;
            a_next    = cmd.a;
            b_next    = cmd.b;
            r_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= mpe_pkg::OP_REDUCE;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            op_reg   <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        r_reg <= r_next;
    end

    assign stat.busy   = busy_reg;
    assign stat.done   = done_reg;
    assign stat.result = r_reg;

endmodule

>>> hw/rtl/multivariate_poly_eval_mod_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multivariate_poly_eval_mod_core
// Sums coeff * prod(point_j ^ exp_j) mod n over terms; emits sum on last.
// ----------------------------------------------------------------------------
// Schedule: each modular step (reduce or multiply) runs on the one bit-serial
//   mod unit; a term takes K steps from accept, K = 2 + min(NUM_VARS, 4)
//   + per variable popcount(e) + (bit length of e) - 1 (nonzero e); after the
//   last term's final step, S_OUT sets m_tvalid once prior output is taken.
// Throughput: one term at a time; s_tready is high only between terms.
// Reset: asynchronous active low; modulus 1, points 0, sum 0, no output.
module multivariate_poly_eval_mod_core
#(
    parameter int NUM_VARS = 4,
    parameter int EXP_BITS = 16
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [mpe_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [63:0]                     cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [127:0]                    s_tdata,  // coefficient, exponent_0..3
    input  logic                            s_tlast,  // last_term
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [63:0]                     m_tdata   // value
);

    `include "multivariate_poly_eval_mod_core_macros.svh"

    localparam int W  = mpe_pkg::WORD_W;
    localparam int EW = mpe_pkg::EXP_W;
    localparam int ACT_VARS = (NUM_VARS < mpe_pkg::VARS) ? NUM_VARS : mpe_pkg::VARS;
    localparam int MB = (EXP_BITS < EW) ? EXP_BITS : EW;
    localparam logic [EW-1:0] EXP_MASK = EW'((17'd1 << MB) - 17'd1);
    localparam logic [1:0] LAST_VAR = 2'(ACT_VARS - 1);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_RCOF = 7'b0000010,
        S_RPT  = 7'b0000100,
        S_MTP  = 7'b0001000,
        S_MSQ  = 7'b0010000,
        S_RSUM = 7'b0100000,
        S_OUT  = 7'b1000000
    } state_t;

    state_t              state_reg, state_next;
    logic [W-1:0]        modulus_reg;
    logic [W-1:0]        point_reg [mpe_pkg::VARS];
    logic [W-1:0]        sum_reg, sum_next;
    logic [W-1:0]        tp_reg, tp_next;
    logic [W-1:0]        sq_reg, sq_next;
    logic [EW-1:0]       exp_reg [mpe_pkg::VARS];
    logic [EW-1:0]       e_reg, e_next;
    logic [1:0]          vi_reg, vi_next;
    logic                last_reg;
    logic                ov_reg, ov_next;
    logic [W-1:0]        out_reg, out_next;
    logic [W-1:0]        n_eff;
    logic [W:0]          add_s;
    logic                accept;
    mpe_pkg::mm_cmd_t    cmd;
    mpe_pkg::mm_stat_t   stat;

    assign n_eff  = (modulus_reg == '0) ? W'(1) : modulus_reg;
    assign accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);

    mpe_mulmod u_mulmod
    (
        .clk   (clk),
        .rst_n (rst_n),
        .n     (n_eff),
        .cmd   (cmd),
        .stat  (stat)
    );

    always_comb
    begin
        logic [EW-1:0] ev;
        state_next = state_reg;
        sum_next   = sum_reg;
        tp_next    = tp_reg;
        sq_next    = sq_reg;
        e_next     = e_reg;
        vi_next    = vi_reg;
        ov_next    = ov_reg;
        out_next   = out_reg;
        cmd.start  = 1'b0;
        cmd.op     = mpe_pkg::OP_REDUCE;
        cmd.a      = '0;
        cmd.b      = '0;
        ev         = e_reg;
        add_s      = {1'b0, stat.result} + {1'b0, tp_reg};
        if (add_s >= {1'b0, n_eff})
        begin
            add_s = add_s - {1'b0, n_eff};
        end
        if (m_tvalid && m_tready)
        begin
            ov_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.start  = 1'b1;
                    cmd.b      = s_tdata[63:0];
                    state_next = S_RCOF;
                end
            end
            S_RCOF:
            begin
                if (stat.done)
                begin
                    tp_next    = stat.result;
                    vi_next    = '0;
                    e_next     = exp_reg[0];
                    cmd.start  = 1'b1;
                    cmd.b      = point_reg[0];
                    state_next = S_RPT;
                end
            end
            S_RPT, S_MTP, S_MSQ:
            begin
                if (stat.done)
                begin
                    if (state_reg == S_RPT)
                    begin
                        sq_next = stat.result;
                    end
                    else if (state_reg == S_MTP)
                    begin
                        tp_next = stat.result;
                    end
                    else
                    begin
                        sq_next = stat.result;
                        ev      = e_reg >> 1;
                        e_next  = ev;
                    end
                    if (state_reg != S_MTP && ev[0])
                    begin
                        cmd.start  = 1'b1;
                        cmd.op     = mpe_pkg::OP_MUL;
                        cmd.a      = tp_next;
                        cmd.b      = sq_next;
                        state_next = S_MTP;
                    end
                    else if (ev[EW-1:1] != '0)
                    begin
                        cmd.start  = 1'b1;
                        cmd.op     = mpe_pkg::OP_MUL;
                        cmd.a      = sq_next;
                        cmd.b      = sq_next;
                        state_next = S_MSQ;
                    end
                    else if (vi_reg == LAST_VAR)
                    begin
                        cmd.start  = 1'b1;
                        cmd.b      = sum_reg;
                        state_next = S_RSUM;
                    end
                    else
                    begin
                        vi_next    = vi_reg + 2'd1;
                        e_next     = exp_reg[vi_next];
                        cmd.start  = 1'b1;
                        cmd.b      = point_reg[vi_next];
                        state_next = S_RPT;
                    end
                end
            end
            S_RSUM:
            begin
                if (stat.done)
                begin
                    sum_next   = add_s[W-1:0];
                    state_next = last_reg ? S_OUT : S_IDLE;
                end
            end
            S_OUT:
            begin
                if (!ov_reg || m_tready)
                begin
                    out_next   = sum_reg;
                    ov_next    = 1'b1;
                    sum_next   = '0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            modulus_reg <= W'(1);
            for (int i = 0; i < mpe_pkg::VARS; i++)
            begin
                point_reg[i] <= '0;
            end
            sum_reg     <= '0;
            vi_reg      <= '0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sum_reg   <= sum_next;
            vi_reg    <= vi_next;
            ov_reg    <= ov_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    mpe_pkg::REG_MODULUS: modulus_reg  <= cfg_data;
                    mpe_pkg::REG_POINT_0: point_reg[0] <= cfg_data;
                    mpe_pkg::REG_POINT_1: point_reg[1] <= cfg_data;
                    mpe_pkg::REG_POINT_2: point_reg[2] <= cfg_data;
                    mpe_pkg::REG_POINT_3: point_reg[3] <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tp_reg  <= tp_next;
        sq_reg  <= sq_next;
        e_reg   <= e_next;
        out_reg <= out_next;
        if (accept)
        begin
            last_reg <= s_tlast;
            for (int j = 0; j < mpe_pkg::VARS; j++)
            begin
                exp_reg[j] <= (j < ACT_VARS) ? (s_tdata[W + EW*j +: EW] & EXP_MASK) : '0;
            end
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = out_reg;

    `MPE_ASSERT_NOW(a_idle_unit_free, s_tready, !stat.busy, "unit busy while ready")
    `MPE_ASSERT_NOW(a_result_range, stat.done, stat.result < n_eff, "mod unit out of range")
    `MPE_ASSERT_NEXT(a_accept_leaves_idle, accept, !s_tready && stat.busy,
        "term not started")

endmodule
